@@ rtl/pnn_pkg.sv @@
`default_nettype none

package pnn_pkg;

	// Vertex coordinates, Q4.12
	localparam int COORD_W  = 16;
	localparam int DIFF_W   = COORD_W + 1;
	// Newell sums wrap at this width
	localparam int SUM_W    = 48;
	// Shared multiplier
	localparam int MUL_W    = 32;
	localparam int PROD_W   = 2 * MUL_W;
	// Normalization: top set bit of the largest magnitude lands here
	localparam int NORM_TOP = 29;
	localparam int MAG_W    = NORM_TOP + 1;
	// Sum of three squares of MAG_W-bit values
	localparam int SQ_W     = 2 * MAG_W + 2;
	localparam int ROOT_W   = SQ_W / 2;
	// Output fraction bits and quotient width (quotient never exceeds 2^FRAC_W)
	localparam int FRAC_W   = 14;
	localparam int QUOT_W   = FRAC_W + 1;
	localparam int DIV_CNT_W = $clog2(QUOT_W);
	localparam int OUT_W    = 16;
	localparam int OUT_MAX  = 1 << FRAC_W;
	// Threshold register and small-magnitude test
	localparam int CFG_W    = 16;
	localparam int SMALL_W  = CFG_W;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic [SUM_W-1:0]          sum_t;
	typedef logic signed [MUL_W-1:0]   mul_op_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic [SQ_W-1:0]           sq_t;
	typedef logic [ROOT_W-1:0]         root_t;
	typedef logic [MAG_W-1:0]          norm_t;
	typedef logic [QUOT_W-1:0]         quot_t;
	typedef logic signed [OUT_W-1:0]   out_t;

endpackage

`default_nettype wire

@@ rtl/pnn_mul.sv @@
`default_nettype none

module pnn_mul (
	input  wire logic              clk,
	input  wire pnn_pkg::mul_op_t  op_a,
	input  wire pnn_pkg::mul_op_t  op_b,
	output pnn_pkg::prod_t         prod
);
	import pnn_pkg::*;

	prod_t prod_q;

	// Signed product, registered
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

@@ rtl/pnn_sqrt.sv @@
`default_nettype none

module pnn_sqrt (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire pnn_pkg::sq_t   radicand,
	output logic                done,
	output pnn_pkg::root_t      root
);
	import pnn_pkg::*;

	logic run_q;
	logic done_q;
	sq_t  rem_q;
	sq_t  res_q;
	sq_t  bit_q;
	sq_t  trial;
	logic ge;

	assign trial = res_q + bit_q;
	assign ge    = (rem_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[0]) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// One result bit per cycle, highest power of four first
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

`default_nettype wire

@@ rtl/pnn_div.sv @@
`default_nettype none

module pnn_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire pnn_pkg::norm_t  num,
	input  wire pnn_pkg::root_t  den,
	output logic                 done,
	output pnn_pkg::quot_t       quot
);
	import pnn_pkg::*;

	localparam int REM_W = MAG_W + FRAC_W;
	localparam int DEN_W = ROOT_W + FRAC_W;

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [REM_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	quot_t                quot_q;
	logic                 ge;

	// Numerator is below twice the divisor, so QUOT_W restoring steps suffice
	assign ge = ({{(DEN_W-REM_W){1'b0}}, rem_q} >= den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(QUOT_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {num, {FRAC_W{1'b0}}};
			den_q  <= {den, {FRAC_W{1'b0}}};
			quot_q <= '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - den_q[REM_W-1:0];
			end
			quot_q <= {quot_q[QUOT_W-2:0], ge};
			den_q  <= den_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

@@ rtl/polygon_normal_newell_top.sv @@
`default_nettype none

// Polygon unit normal by Newell's method.
//
// Input: one vertex per transaction (x, y, z in Q4.12, last marks the loop's
// final vertex), taken at a rising edge where start is high and busy is low.
// Output: on the last vertex only, one result (nx, ny, nz in Q2.14 and
// degenerate) shown for exactly one cycle with done high; the receiver takes
// it at that edge and cannot stall the block.
// Configuration: cfg_data writes min_length whenever cfg_valid is high;
// cfg_ready is always high. Write it only while the block is idle.
// Sequence: the first vertex of a loop runs no product. Every later vertex runs
// the three Newell products through the one shared multiplier, with busy high
// while it does. The last vertex adds the closing pair, then takes the
// magnitudes, the small-length test (with squares only when all magnitudes fit
// 16 bits), a one-bit-per-cycle normalization, the squares, the square root and
// three divisions; a degenerate result ends after the small-length test.
// Reset: arst_n clears the loop state and sets min_length to zero; the next
// vertex then starts a new polygon.

module polygon_normal_newell_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// vertex input
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [pnn_pkg::COORD_W-1:0] x,
	input  wire logic signed [pnn_pkg::COORD_W-1:0] y,
	input  wire logic signed [pnn_pkg::COORD_W-1:0] z,
	input  wire logic                          last,
	// result output
	output logic                               done,
	output logic signed [pnn_pkg::OUT_W-1:0]   nx,
	output logic signed [pnn_pkg::OUT_W-1:0]   ny,
	output logic signed [pnn_pkg::OUT_W-1:0]   nz,
	output logic                               degenerate,
	// min_length write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [pnn_pkg::CFG_W-1:0]     cfg_data
);
	import pnn_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAIR,
		S_MAG,
		S_SMALL,
		S_NORM,
		S_SQ,
		S_ROOT,
		S_DIV
	} state_t;

	localparam logic [2:0] CNT_PAIR_END = 3'd3;
	localparam logic [2:0] CNT_SQ_END   = 3'd4;
	localparam logic [2:0] CNT_DIV_END  = 3'd2;

	state_t           state_q;
	logic [2:0]       cnt_q;
	logic             loop_open_q;
	logic             pend_close_q;
	logic             emit_q;
	logic [CFG_W-1:0] ml_q;
	logic             done_q;
	logic             degen_q;
	out_t             nx_q;
	out_t             ny_q;
	out_t             nz_q;

	coord_t vtx     [3];
	coord_t first_q [3];
	coord_t prev_q  [3];
	coord_t a_q     [3];
	coord_t b_q     [3];
	sum_t   sum_q   [3];
	sum_t   mag_q   [3];
	logic   neg_q   [3];
	quot_t  q_q     [2];
	sq_t    sq_q;

	logic    accept;
	diff_t   dif;
	diff_t   add;
	mul_op_t mul_a;
	mul_op_t mul_b;
	prod_t   prod;
	sq_t     ml_sq;
	sum_t    or_mag;
	logic    mag_big;
	logic    shr;
	logic    norm_ok;
	logic    sqrt_start;
	logic    sqrt_done;
	root_t   root;
	logic    div_start;
	norm_t   div_num;
	logic    div_done;
	quot_t   quot;

	assign vtx[0] = x;
	assign vtx[1] = y;
	assign vtx[2] = z;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign ml_sq   = {{(SQ_W-2*CFG_W){1'b0}}, prod[2*CFG_W-1:0]};
	assign or_mag  = mag_q[0] | mag_q[1] | mag_q[2];
	assign mag_big = |or_mag[SUM_W-1:SMALL_W];
	assign shr     = |or_mag[SUM_W-1:MAG_W];
	assign norm_ok = !shr && or_mag[NORM_TOP];

	// Feed the shared multiplier: Newell terms, then squares
	always_comb begin
		dif   = '0;
		add   = '0;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_PAIR: begin
				case (cnt_q)
					3'd0: begin
						dif = DIFF_W'(a_q[1]) - DIFF_W'(b_q[1]);
						add = DIFF_W'(a_q[2]) + DIFF_W'(b_q[2]);
					end
					3'd1: begin
						dif = DIFF_W'(a_q[2]) - DIFF_W'(b_q[2]);
						add = DIFF_W'(a_q[0]) + DIFF_W'(b_q[0]);
					end
					3'd2: begin
						dif = DIFF_W'(a_q[0]) - DIFF_W'(b_q[0]);
						add = DIFF_W'(a_q[1]) + DIFF_W'(b_q[1]);
					end
					default: ;
				endcase
				mul_a = MUL_W'(dif);
				mul_b = MUL_W'(add);
			end
			S_SMALL: begin
				case (cnt_q)
					3'd0: mul_a = MUL_W'(mag_q[0][SMALL_W-1:0]);
					3'd1: mul_a = MUL_W'(mag_q[1][SMALL_W-1:0]);
					3'd2: mul_a = MUL_W'(mag_q[2][SMALL_W-1:0]);
					3'd3: mul_a = MUL_W'(ml_q);
					default: ;
				endcase
				mul_b = mul_a;
			end
			S_SQ: begin
				case (cnt_q)
					3'd0: mul_a = MUL_W'(mag_q[0][MAG_W-1:0]);
					3'd1: mul_a = MUL_W'(mag_q[1][MAG_W-1:0]);
					3'd2: mul_a = MUL_W'(mag_q[2][MAG_W-1:0]);
					default: ;
				endcase
				mul_b = mul_a;
			end
			default: ;
		endcase
	end

	pnn_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	// Square root of the normalized sum of squares
	assign sqrt_start = (state_q == S_SQ) && (cnt_q == CNT_SQ_END);

	pnn_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sq_q),
		.done     (sqrt_done),
		.root     (root)
	);

	// Three divisions in turn: the first starts as the square root finishes, each later one as the previous one finishes
	always_comb begin
		div_start = 1'b0;
		div_num   = mag_q[0][MAG_W-1:0];
		case (state_q)
			S_ROOT: begin
				div_start = sqrt_done;
			end
			S_DIV: begin
				div_start = div_done && (cnt_q != CNT_DIV_END);
				case (cnt_q)
					3'd0:    div_num = mag_q[1][MAG_W-1:0];
					default: div_num = mag_q[2][MAG_W-1:0];
				endcase
			end
			default: ;
		endcase
	end

	pnn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (root),
		.done   (div_done),
		.quot   (quot)
	);

	function automatic out_t apply_sign(input quot_t q, input logic neg);
		out_t m;
		m = out_t'(q);
		return neg ? -m : m;
	endfunction

	// Sequencer: state, loop flags, threshold and the result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			loop_open_q  <= 1'b0;
			pend_close_q <= 1'b0;
			emit_q       <= 1'b0;
			ml_q         <= '0;
			done_q       <= 1'b0;
			degen_q      <= 1'b0;
			nx_q         <= '0;
			ny_q         <= '0;
			nz_q         <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				ml_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (!loop_open_q) begin
							// first vertex: a lone vertex closes on itself
							if (last) begin
								state_q <= S_MAG;
							end else begin
								loop_open_q <= 1'b1;
							end
						end else begin
							state_q      <= S_PAIR;
							pend_close_q <= last;
							if (last) begin
								loop_open_q <= 1'b0;
							end
						end
					end
				end
				S_PAIR: begin
					if (cnt_q == CNT_PAIR_END) begin
						cnt_q <= '0;
						if (pend_close_q) begin
							// rerun for the closing pair
							pend_close_q <= 1'b0;
							emit_q       <= 1'b1;
						end else if (emit_q) begin
							emit_q  <= 1'b0;
							state_q <= S_MAG;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MAG: begin
					state_q <= S_SMALL;
					cnt_q   <= '0;
				end
				S_SMALL: begin
					if (cnt_q == '0 && mag_big) begin
						state_q <= S_NORM;
					end else if (cnt_q == CNT_SQ_END) begin
						cnt_q <= '0;
						if (sq_q <= ml_sq) begin
							done_q  <= 1'b1;
							degen_q <= 1'b1;
							nx_q    <= '0;
							ny_q    <= '0;
							nz_q    <= '0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_NORM;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_NORM: begin
					if (norm_ok) begin
						state_q <= S_SQ;
						cnt_q   <= '0;
					end
				end
				S_SQ: begin
					if (cnt_q == CNT_SQ_END) begin
						state_q <= S_ROOT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ROOT: begin
					if (sqrt_done) begin
						state_q <= S_DIV;
						cnt_q   <= '0;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (cnt_q == CNT_DIV_END) begin
							done_q  <= 1'b1;
							degen_q <= 1'b0;
							nx_q    <= apply_sign(q_q[0], neg_q[0]);
							ny_q    <= apply_sign(q_q[1], neg_q[1]);
							nz_q    <= apply_sign(quot, neg_q[2]);
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!loop_open_q) begin
						for (int i = 0; i < 3; i++) begin
							first_q[i] <= vtx[i];
							prev_q[i]  <= vtx[i];
							sum_q[i]   <= '0;
						end
					end else begin
						for (int i = 0; i < 3; i++) begin
							a_q[i]    <= prev_q[i];
							b_q[i]    <= vtx[i];
							prev_q[i] <= vtx[i];
						end
					end
				end
			end
			S_PAIR: begin
				case (cnt_q)
					3'd1: sum_q[0] <= sum_q[0] + prod[SUM_W-1:0];
					3'd2: sum_q[1] <= sum_q[1] + prod[SUM_W-1:0];
					3'd3: begin
						sum_q[2] <= sum_q[2] + prod[SUM_W-1:0];
						if (pend_close_q) begin
							for (int i = 0; i < 3; i++) begin
								a_q[i] <= b_q[i];
								b_q[i] <= first_q[i];
							end
						end
					end
					default: ;
				endcase
			end
			S_MAG: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= sum_q[i][SUM_W-1];
					mag_q[i] <= sum_q[i][SUM_W-1] ? -sum_q[i] : sum_q[i];
				end
			end
			S_SMALL, S_SQ: begin
				case (cnt_q)
					3'd1:       sq_q <= prod[SQ_W-1:0];
					3'd2, 3'd3: sq_q <= sq_q + prod[SQ_W-1:0];
					default: ;
				endcase
			end
			S_NORM: begin
				// move the top set bit one place per cycle toward NORM_TOP
				if (shr) begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] >> 1;
					end
				end else if (!or_mag[NORM_TOP]) begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] << 1;
					end
				end
			end
			S_DIV: begin
				if (div_done) begin
					case (cnt_q)
						3'd0: q_q[0] <= quot;
						3'd1: q_q[1] <= quot;
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign done       = done_q;
	assign degenerate = degen_q;
	assign nx         = nx_q;
	assign ny         = ny_q;
	assign nz         = nz_q;

	// A result only ends a busy stretch
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// A degenerate result carries a zero vector
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (nx == '0 && ny == '0 && nz == '0))
		else $error("degenerate result with nonzero components");

	// Normal components stay within unit range
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !degenerate) |->
			(nx <= OUT_MAX && nx >= -OUT_MAX && ny <= OUT_MAX && ny >= -OUT_MAX &&
			 nz <= OUT_MAX && nz >= -OUT_MAX))
		else $error("normal component out of range");

endmodule

`default_nettype wire
